// ===== rtl/tie_pkg.sv =====
// Shared constants, opcode codes, execute result type and helpers for the tiny ISA executor.
package tie_pkg;

   localparam int REG_COUNT      = 16;
   localparam int REG_BITS       = $clog2(REG_COUNT);
   localparam int WORD_BITS      = 32;
   localparam int INSTR_BITS     = 16;
   // power of two, 16..256 (one valid flop per entry)
   localparam int DMEM_DEPTH     = 256;
   localparam int DMEM_ADDR_BITS = $clog2(DMEM_DEPTH);
   localparam int PC_BITS        = 16;
   localparam int PC_FIELD_BITS  = 16;
   localparam int ADDR_FIELD_BITS = 8;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_LD   = 3'd3,
      OP_ST   = 3'd4,
      OP_JMP  = 3'd5,
      OP_BEQZ = 3'd6,
      OP_SYS  = 3'd7
   } opcode_type;

   typedef struct packed {
      logic [PC_BITS-1:0]        next_pc;
      logic                      reg_write;
      logic [REG_BITS-1:0]       dest_reg;
      logic [WORD_BITS-1:0]      value;
      logic                      mem_read;
      logic                      mem_write;
      logic [DMEM_ADDR_BITS-1:0] mem_index;
      logic [WORD_BITS-1:0]      store_data;
      logic                      branch_taken;
      logic                      halt_now;
   } exec_result_type;

   function automatic opcode_type instr_opcode(input logic [INSTR_BITS-1:0] instr);
      return opcode_type'(instr[15:13]);
   endfunction

   // first register read port: R[a] for store and branch, R[b] otherwise
   function automatic logic [REG_BITS-1:0] port_a_addr(input logic [INSTR_BITS-1:0] instr);
      opcode_type op;
      op = instr_opcode(instr);
      if (op == OP_ST || op == OP_BEQZ) begin
         return instr[11:8];
      end
      return instr[7:4];
   endfunction

   // second register read port: R[b] for store, R[c] otherwise
   function automatic logic [REG_BITS-1:0] port_b_addr(input logic [INSTR_BITS-1:0] instr);
      if (instr_opcode(instr) == OP_ST) begin
         return instr[7:4];
      end
      return instr[3:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] sext4(input logic [3:0] v);
      return {{(WORD_BITS-4){v[3]}}, v};
   endfunction

   // base + 2 * sext8(off), wrapped to the PC width
   function automatic logic [PC_BITS-1:0] branch_target(input logic [PC_BITS-1:0] base,
                                                         input logic [7:0] off);
      logic [31:0] wide;
      wide = 32'(base) + {{23{off[7]}}, off, 1'b0};
      return wide[PC_BITS-1:0];
   endfunction

   function automatic logic [PC_FIELD_BITS-1:0] pc_field(input logic [PC_BITS-1:0] pc);
      logic [31:0] wide;
      wide = 32'(pc);
      return wide[PC_FIELD_BITS-1:0];
   endfunction

   function automatic logic [ADDR_FIELD_BITS-1:0] addr_field(
         input logic [DMEM_ADDR_BITS-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[ADDR_FIELD_BITS-1:0];
   endfunction

endpackage

// ===== rtl/tie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tie_alu.sv =====
// Instruction decode and execute: ALU, address, branch and halt decisions.
module tie_alu
   import tie_pkg::*;
(
   input  logic [INSTR_BITS-1:0] instruction,
   input  logic [PC_BITS-1:0]    pc,
   input  logic [WORD_BITS-1:0]  opnd_a,
   input  logic [WORD_BITS-1:0]  opnd_b,
   output exec_result_type       result
);

   opcode_type           op;
   logic                 imm;
   logic [WORD_BITS-1:0] src;
   logic [PC_BITS-1:0]   base;

   assign op   = instr_opcode(instruction);
   assign imm  = instruction[12];
   assign src  = imm ? sext4(instruction[3:0]) : opnd_b;
   assign base = pc + PC_BITS'(2);

   always_comb begin
      result         = '0;
      result.next_pc = base;
      unique case (op)
         OP_ADD: begin
            result.reg_write = 1'b1;
            result.dest_reg  = instruction[11:8];
            result.value     = opnd_a + src;
         end
         OP_SUB: begin
            result.reg_write = 1'b1;
            result.dest_reg  = instruction[11:8];
            result.value     = opnd_a - src;
         end
         OP_MUL: begin
            result.reg_write = 1'b1;
            result.dest_reg  = instruction[11:8];
            result.value     = opnd_a * src;
         end
         OP_LD: begin
            // value arrives from data memory one stage later
            result.reg_write = 1'b1;
            result.dest_reg  = instruction[11:8];
            result.mem_read  = 1'b1;
            result.mem_index = opnd_a[DMEM_ADDR_BITS-1:0];
         end
         OP_ST: begin
            result.mem_write  = 1'b1;
            result.mem_index  = opnd_a[DMEM_ADDR_BITS-1:0];
            result.store_data = opnd_b;
         end
         OP_JMP: begin
            result.next_pc      = branch_target(base, instruction[11:4]);
            result.branch_taken = 1'b1;
         end
         OP_BEQZ: begin
            if (opnd_a == '0) begin
               result.next_pc      = branch_target(base, instruction[7:0]);
               result.branch_taken = 1'b1;
            end
         end
         OP_SYS: begin
            // flag set: no operation, flag clear: halt
            result.halt_now = !imm;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/tiny_isa_instruction_executor.sv =====
// A result is offered once its accepted instruction has passed stage 1 and loaded the stage 2 result register.
// Throughput: one instruction per cycle; only a stalled result holds the pipeline.
// Register file: two registered-read RAM copies; data memory: one registered-read RAM.
// Both stores read as zero after reset through per-entry valid flops (16 + DMEM_DEPTH).
// Reset (synchronous, active high) clears PC, halt flag, valid flops and pipeline.
module tiny_isa_instruction_executor
   import tie_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // instruction channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [INSTR_BITS-1:0]      req_instruction,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [PC_FIELD_BITS-1:0]   rsp_next_pc,
   output logic                       rsp_reg_write,
   output logic [REG_BITS-1:0]        rsp_dest_reg,
   output logic signed [WORD_BITS-1:0] rsp_dest_value,
   output logic                       rsp_mem_write,
   output logic [ADDR_FIELD_BITS-1:0] rsp_mem_addr,
   output logic signed [WORD_BITS-1:0] rsp_mem_data,
   output logic                       rsp_branch_taken,
   output logic                       rsp_halted
);

   // ------------------------------------------------------------------
   // Pipeline control. Stage 1 holds the instruction plus register read
   // data, stage 2 is the result register. The whole pipeline moves on
   // "advance"; it only freezes while a result transaction is stalled.
   // ------------------------------------------------------------------
   logic advance;
   logic req_accept;
   logic wb_en;

   assign advance    = !(rsp_valid && rsp_stall);
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;

   // stage 1 registers
   logic                  s1_valid_ff, s1_valid_in;
   logic [INSTR_BITS-1:0] s1_instr_ff;
   logic                  rfa_valid_ff, rfb_valid_ff;

   // architectural state
   logic [PC_BITS-1:0]    pc_ff, pc_in;
   logic                  halt_ff, halt_in;
   logic [REG_COUNT-1:0]  rf_valid_ff, rf_valid_in;
   logic [DMEM_DEPTH-1:0] dm_valid_ff, dm_valid_in;

   // last register write, for the same-edge read/write case
   logic                  wb_valid_ff;
   logic [REG_BITS-1:0]   wb_reg_ff;
   logic [WORD_BITS-1:0]  wb_value_ff;

   // stage 2 (result) registers
   logic                  s2_valid_ff, s2_valid_in;
   exec_result_type       s2_res_ff, s2_res_in;
   logic                  s2_halted_ff, s2_halted_in;
   logic                  s2_ld_valid_ff;

   // ------------------------------------------------------------------
   // Register file: two copies so each read port has its own RAM.
   // Reads are launched as the instruction enters stage 1.
   // ------------------------------------------------------------------
   logic [REG_BITS-1:0]  rda_addr, rdb_addr;
   logic [WORD_BITS-1:0] rfa_data, rfb_data;
   logic [WORD_BITS-1:0] wb_value;

   assign rda_addr = port_a_addr(req_instruction);
   assign rdb_addr = port_b_addr(req_instruction);
   assign wb_en    = rsp_valid && !rsp_stall && rsp_reg_write;
   assign wb_value = $unsigned(rsp_dest_value);

   tie_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_a (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (rsp_dest_reg),
      .wr_data (wb_value),
      .rd_en   (advance),
      .rd_addr (rda_addr),
      .rd_data (rfa_data)
   );

   tie_ram #(.WIDTH(WORD_BITS), .DEPTH(REG_COUNT)) u_rf_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (rsp_dest_reg),
      .wr_data (wb_value),
      .rd_en   (advance),
      .rd_addr (rdb_addr),
      .rd_data (rfb_data)
   );

   // ------------------------------------------------------------------
   // Operand bypass. RAM data was read at the edge stage 1 loaded, so it
   // misses the write retired at that same edge (wb_*) and the one still
   // in stage 2 (taken straight from the result outputs, load data too).
   // ------------------------------------------------------------------
   function automatic logic [WORD_BITS-1:0] bypass(
         input logic [WORD_BITS-1:0] ram_data,
         input logic                 ram_valid,
         input logic                 s2_hit,
         input logic [WORD_BITS-1:0] s2_value,
         input logic                 wb_hit,
         input logic [WORD_BITS-1:0] wb_val);
      if (s2_hit) begin
         return s2_value;
      end
      if (wb_hit) begin
         return wb_val;
      end
      if (ram_valid) begin
         return ram_data;
      end
      return '0;
   endfunction

   logic [REG_BITS-1:0]  s1_addr_a, s1_addr_b;
   logic [WORD_BITS-1:0] opnd_a, opnd_b;
   logic                 s2_fwd;

   assign s1_addr_a = port_a_addr(s1_instr_ff);
   assign s1_addr_b = port_b_addr(s1_instr_ff);
   assign s2_fwd    = s2_valid_ff && s2_res_ff.reg_write;

   assign opnd_a = bypass(rfa_data, rfa_valid_ff,
                          s2_fwd && (s2_res_ff.dest_reg == s1_addr_a), wb_value,
                          wb_valid_ff && (wb_reg_ff == s1_addr_a), wb_value_ff);
   assign opnd_b = bypass(rfb_data, rfb_valid_ff,
                          s2_fwd && (s2_res_ff.dest_reg == s1_addr_b), wb_value,
                          wb_valid_ff && (wb_reg_ff == s1_addr_b), wb_value_ff);

   // ------------------------------------------------------------------
   // Execute
   // ------------------------------------------------------------------
   exec_result_type alu_res;

   tie_alu u_alu (
      .instruction (s1_instr_ff),
      .pc          (pc_ff),
      .opnd_a      (opnd_a),
      .opnd_b      (opnd_b),
      .result      (alu_res)
   );

   // once halted, every transaction reports the frozen PC and the halted flag and nothing else
   always_comb begin
      if (halt_ff) begin
         s2_res_in         = '0;
         s2_res_in.next_pc = pc_ff;
         s2_halted_in      = 1'b1;
      end else begin
         s2_res_in    = alu_res;
         s2_halted_in = alu_res.halt_now;
      end
   end

   logic s1_live;
   logic dm_wr_en;

   assign s1_live  = advance && s1_valid_ff;
   assign dm_wr_en = s1_live && s2_res_in.mem_write;

   // ------------------------------------------------------------------
   // Data memory: load and store both happen as the instruction moves from
   // stage 1 into stage 2, in program order, so no bypass is needed here.
   // ------------------------------------------------------------------
   logic [WORD_BITS-1:0] dm_rd_data;

   tie_ram #(.WIDTH(WORD_BITS), .DEPTH(DMEM_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_wr_en),
      .wr_addr (s2_res_in.mem_index),
      .wr_data (s2_res_in.store_data),
      .rd_en   (advance),
      .rd_addr (s2_res_in.mem_index),
      .rd_data (dm_rd_data)
   );

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      pc_in       = pc_ff;
      halt_in     = halt_ff;
      rf_valid_in = rf_valid_ff;
      dm_valid_in = dm_valid_ff;
      if (advance) begin
         s1_valid_in = req_accept;
         s2_valid_in = s1_valid_ff;
      end
      if (s1_live) begin
         pc_in   = s2_res_in.next_pc;
         halt_in = s2_halted_in;
      end
      if (wb_en) begin
         rf_valid_in[rsp_dest_reg] = 1'b1;
      end
      if (dm_wr_en) begin
         dm_valid_in[s2_res_in.mem_index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pc_ff       <= '0;
         halt_ff     <= 1'b0;
         rf_valid_ff <= '0;
         dm_valid_ff <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         pc_ff       <= pc_in;
         halt_ff     <= halt_in;
         rf_valid_ff <= rf_valid_in;
         dm_valid_ff <= dm_valid_in;
         if (advance) begin
            wb_valid_ff <= wb_en;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_instr_ff    <= req_instruction;
         rfa_valid_ff   <= rf_valid_ff[rda_addr];
         rfb_valid_ff   <= rf_valid_ff[rdb_addr];
         wb_reg_ff      <= rsp_dest_reg;
         wb_value_ff    <= wb_value;
         s2_res_ff      <= s2_res_in;
         s2_halted_ff   <= s2_halted_in;
         s2_ld_valid_ff <= dm_valid_ff[s2_res_in.mem_index];
      end
   end

   // ------------------------------------------------------------------
   // Result transaction
   // ------------------------------------------------------------------
   logic [WORD_BITS-1:0] ld_word;

   assign ld_word = (s2_res_ff.mem_read && s2_ld_valid_ff) ? dm_rd_data : '0;

   assign rsp_valid        = s2_valid_ff;
   assign rsp_next_pc      = pc_field(s2_res_ff.next_pc);
   assign rsp_reg_write    = s2_res_ff.reg_write;
   assign rsp_dest_reg     = s2_res_ff.dest_reg;
   assign rsp_dest_value   = $signed(s2_res_ff.mem_read ? ld_word : s2_res_ff.value);
   assign rsp_mem_write    = s2_res_ff.mem_write;
   assign rsp_mem_addr     = addr_field(s2_res_ff.mem_index);
   assign rsp_mem_data     = $signed(s2_res_ff.mem_read ? ld_word : s2_res_ff.store_data);
   assign rsp_branch_taken = s2_res_ff.branch_taken;
   assign rsp_halted       = s2_halted_ff;

`ifndef ASSERT_OFF
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_stall_freezes_pc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(pc_ff) && $stable(halt_ff))
      else $error("architectural state moved during a stalled result");

   a_store_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mem_write) |-> (!rsp_reg_write && !rsp_branch_taken))
      else $error("store transaction reports a register write or branch");

   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && halt_ff) |-> (!dm_wr_en && !s2_res_in.reg_write))
      else $error("instruction after halt has side effects");
`endif

endmodule
